/* hw/rtl/ptts_pkg.sv */
// Shared types and field widths for the periodic task tick scheduler.
// No dependencies; imported by the top level and the timer store.
package ptts_pkg;

    // Item kinds carried on the input channel
    typedef enum logic [1:0] {
        KIND_SCHEDULE = 2'd0,
        KIND_SET      = 2'd1,
        KIND_TICK     = 2'd2,
        KIND_QUERY    = 2'd3
    } t_kind;

    // Fixed field widths of the item and result
    localparam int TASK_REQ_W = 3;
    localparam int PERIOD_W   = 16;
    localparam int DUE_MASK_W = 8;
    localparam int OVF_TASK_W = 3;

    // Write request into the timer store, address and data travel beside it
    typedef struct packed {
        logic en;
    } t_wr_ctl;

endpackage

/* hw/rtl/ptts_timer_mem.sv */
// Per-task timer store: one synchronous memory of {reload, countdown} words.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on ptts_pkg for the write control struct.
module ptts_timer_mem
    import ptts_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_wr_ctl       i_wr_ctl,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_vld;

    // Write port, no reset on the array
    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_ctl.en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    // Unwritten entries read as their reset value
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* hw/rtl/periodic_task_tick_scheduler.sv */
// Periodic task tick scheduler top level: sequencer, flags and output register.
// Depends on ptts_pkg and ptts_timer_mem.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one item: schedule, set active
//   bit, tick or query. Output channel (o_valid / i_stall) returns exactly one
//   result per item: run_now, the low eight due flags and the overrun task.
//   The block works on one item at a time. o_stall is low only while the
//   sequencer is idle; the output register lets the next item in while the
//   previous result still waits for the receiver.
//   Schedule, set and query items pass from S_EXEC to S_DONE, where the result
//   loads into the output register and raises o_valid. A tick walks the timer
//   memory one entry a cycle with the write back of entry t overlapping the
//   read of entry t+1; the single read port of the timer memory sets this pace.
//   A new item is taken only once the sequencer is back in S_IDLE.
//   Reset (synchronous, active low) clears the active bits, due flags, the
//   overrun task and the valid bits of the timer memory; no clearing pass.
//   When the receiver stalls, the result holds in the output register; a
//   finished item waiting behind it holds the sequencer and o_stall stays high.
module periodic_task_tick_scheduler
    import ptts_pkg::*;
#(
    parameter int TASK_COUNT  = 8,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_kind,
    input  logic [TASK_REQ_W-1:0] i_task_req,
    input  logic [PERIOD_W-1:0]   i_period,
    input  logic                  i_enable,
    input  logic                  i_tick_overrun,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_run_now,
    output logic [DUE_MASK_W-1:0] o_due_mask,
    output logic [OVF_TASK_W-1:0] o_overflow_task
);

    localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int TW = TIMER_WIDTH;
    localparam int DW = 2 * TIMER_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_DONE
    } t_state;

    t_state                r_state;
    t_kind                 r_kind;
    logic [TASK_REQ_W-1:0] r_task;
    logic [PERIOD_W-1:0]   r_period;
    logic                  r_enable;
    logic                  r_ovr;

    logic [TASK_COUNT-1:0] r_active;
    logic [TASK_COUNT-1:0] r_due;
    logic [OVF_TASK_W-1:0] r_ovt;
    logic                  r_run;

    logic [IW:0]           r_idx;
    logic [IW-1:0]         r_widx;
    logic                  r_pend;

    logic                  r_out_valid;
    logic                  r_out_run;
    logic [DUE_MASK_W-1:0] r_out_due;
    logic [OVF_TASK_W-1:0] r_out_ovt;

    logic                  accept;
    logic                  task_ok;
    logic [IW-1:0]         task_idx;
    logic [TW-1:0]         per_tw;
    logic [DW-1:0]         rd_data;
    logic [TW-1:0]         rd_cnt;
    logic [TW-1:0]         rd_rel;
    logic [TW-1:0]         dec_cnt;
    logic                  tick_hit;
    logic [TW-1:0]         new_cnt;
    logic                  widx_active;
    logic                  rd_en;
    logic                  out_free;
    logic                  last_entry;
    t_wr_ctl               wr_ctl;
    logic [IW-1:0]         wr_addr;
    logic [DW-1:0]         wr_data;
    logic [DUE_MASK_W-1:0] due_mask;

    // Input handshake
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // Task decode
    assign task_ok  = (32'(r_task) < TASK_COUNT);
    assign task_idx = IW'(r_task);
    assign per_tw   = TW'(r_period);

    // Decrement and reload of the entry coming out of the memory
    assign rd_cnt      = rd_data[TW-1:0];
    assign rd_rel      = rd_data[DW-1:TW];
    assign dec_cnt     = rd_cnt - TW'(1);
    assign tick_hit    = (dec_cnt == '0);
    assign new_cnt     = tick_hit ? rd_rel : dec_cnt;
    assign widx_active = r_active[r_widx];
    assign last_entry  = (r_widx == IW'(TASK_COUNT - 1));

    // Memory port selection
    assign rd_en = (r_state == S_TICK) && (32'(r_idx) < TASK_COUNT);

    always_comb begin
        wr_ctl.en = 1'b0;
        wr_addr   = task_idx;
        wr_data   = {per_tw, per_tw};
        if (r_state == S_TICK) begin
            wr_ctl.en = r_pend && widx_active;
            wr_addr   = r_widx;
            wr_data   = {rd_rel, new_cnt};
        end else if (r_state == S_EXEC) begin
            wr_ctl.en = (r_kind == KIND_SCHEDULE) && task_ok;
        end
    end

    ptts_timer_mem #(
        .DEPTH (TASK_COUNT),
        .AW    (IW),
        .DW    (DW)
    ) u_timer_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_ctl  (wr_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_data (rd_data)
    );

    // Pack the low due flags, zero above the task count
    for (genvar g = 0; g < DUE_MASK_W; g++) begin : g_mask
        if (g < TASK_COUNT) begin : g_live
            assign due_mask[g] = r_due[g];
        end else begin : g_none
            assign due_mask[g] = 1'b0;
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    // Sequencer, flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_due       <= '0;
            r_ovt       <= '0;
            r_run       <= 1'b0;
            r_idx       <= '0;
            r_widx      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one loads now
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind   <= t_kind'(i_kind);
                        r_task   <= i_task_req;
                        r_period <= i_period;
                        r_enable <= i_enable;
                        r_ovr    <= i_tick_overrun;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_run  <= (r_kind == KIND_QUERY) && task_ok && !r_ovr &&
                              r_due[task_idx];
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    case (r_kind)
                        KIND_SCHEDULE: begin
                            if (task_ok) begin
                                r_active[task_idx] <= 1'b1;
                            end
                            r_state <= S_DONE;
                        end
                        KIND_SET: begin
                            if (task_ok) begin
                                r_active[task_idx] <= r_enable;
                            end
                            r_state <= S_DONE;
                        end
                        KIND_TICK: begin
                            r_state <= S_TICK;
                        end
                        KIND_QUERY: begin
                            if (task_ok && r_ovr) begin
                                r_ovt <= OVF_TASK_W'(r_task);
                            end
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_TICK: begin
                    // Advance the read, write back the previous entry
                    if (rd_en) begin
                        r_idx  <= r_idx + 1'b1;
                        r_widx <= r_idx[IW-1:0];
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_due[r_widx] <= widx_active && tick_hit;
                        if (last_entry) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_pend <= 1'b0;
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_run   <= r_run;
                        r_out_due   <= due_mask;
                        r_out_ovt   <= r_ovt;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_run_now       = r_out_run;
    assign o_due_mask      = r_out_due;
    assign o_overflow_task = r_out_ovt;

`ifndef NO_ASSERTIONS
    // A pending write back always names a task inside the table
    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (32'(r_widx) < TASK_COUNT))
        else $error("write back index beyond task count");

    // Pending memory data only exists while walking the table
    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_TICK))
        else $error("pending read data outside tick walk");

    // An accepted item is executed in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    // A finished item waits while the result register is held
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |=>
            (r_state == S_DONE && r_out_valid))
        else $error("result overwritten under stall");
`endif

endmodule

/* tb/periodic_task_tick_scheduler_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for periodic_task_tick_scheduler: a directed table, then random
// items with bursty input and a stalling receiver, checked against a task-table predictor.
// Depends on ptts_pkg and the scheduler RTL.
module periodic_task_tick_scheduler_test;
    import ptts_pkg::*;

    localparam int TASKS      = 8;
    localparam int TIMER_W    = 16;
    localparam int RAND_ITEMS = 1825;
    localparam int HOLD_AT    = 900;
    localparam int HOLD_LEN   = 300;
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        t_kind                 kind;
        logic [TASK_REQ_W-1:0] task_id;
        logic [PERIOD_W-1:0]   period;
        logic                  enable;
        logic                  overrun;
    } t_item;

    typedef struct {
        logic                  run_now;
        logic [DUE_MASK_W-1:0] due_mask;
        logic [OVF_TASK_W-1:0] ovf_task;
    } t_status;

    typedef struct {
        t_item   it;
        bit      typed;
        t_status st;
    } t_dir_row;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_kind;
    logic [TASK_REQ_W-1:0] i_task_req;
    logic [PERIOD_W-1:0]   i_period;
    logic                  i_enable;
    logic                  i_tick_overrun;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_run_now;
    logic [DUE_MASK_W-1:0] o_due_mask;
    logic [OVF_TASK_W-1:0] o_overflow_task;

    periodic_task_tick_scheduler #(
        .TASK_COUNT  (TASKS),
        .TIMER_WIDTH (TIMER_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_task_req      (i_task_req),
        .i_period        (i_period),
        .i_enable        (i_enable),
        .i_tick_overrun  (i_tick_overrun),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_run_now       (o_run_now),
        .o_due_mask      (o_due_mask),
        .o_overflow_task (o_overflow_task)
    );

    // Predicted task table
    logic               tbl_active [TASKS];
    logic               tbl_due    [TASKS];
    logic [TIMER_W-1:0] tbl_count  [TASKS];
    logic [TIMER_W-1:0] tbl_reload [TASKS];
    logic [2:0]         tbl_ovf;

    t_status  pending_status [$];
    t_dir_row dir_table [$];
    int       mismatches;
    int       results_seen;
    int       kind_seen [4];
    int       due_answers;
    int       overrun_queries;
    int       burst_left;
    bit       hold_request;

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Advance the predicted table by one item and return the status it reports
    function automatic t_status apply_item(t_item it);
        t_status st;
        int t;
        st.run_now = 1'b0;
        case (it.kind)
            KIND_SCHEDULE: begin
                tbl_active[it.task_id] = 1'b1;
                tbl_reload[it.task_id] = it.period[TIMER_W-1:0];
                tbl_count[it.task_id]  = it.period[TIMER_W-1:0];
            end
            KIND_SET: begin
                tbl_active[it.task_id] = it.enable;
            end
            KIND_TICK: begin
                for (t = 0; t < TASKS; t++) begin
                    if (tbl_active[t]) begin
                        tbl_count[t] = tbl_count[t] - 1'b1;
                        if (tbl_count[t] == '0) begin
                            tbl_count[t] = tbl_reload[t];
                            tbl_due[t]   = 1'b1;
                        end else begin
                            tbl_due[t] = 1'b0;
                        end
                    end else begin
                        tbl_due[t] = 1'b0;
                    end
                end
            end
            default: begin
                if (it.overrun) tbl_ovf = it.task_id;
                else st.run_now = tbl_due[it.task_id];
            end
        endcase
        for (t = 0; t < DUE_MASK_W; t++) st.due_mask[t] = (t < TASKS) ? tbl_due[t] : 1'b0;
        st.ovf_task = tbl_ovf;
        return st;
    endfunction

    function automatic void add_row(t_kind kind, int id, int period, bit en, bit ovr,
                                    bit typed, bit run, int mask, int ovf);
        t_dir_row r;
        r.it.kind      = kind;
        r.it.task_id   = id[TASK_REQ_W-1:0];
        r.it.period    = period[PERIOD_W-1:0];
        r.it.enable    = en;
        r.it.overrun   = ovr;
        r.typed        = typed;
        r.st.run_now   = run;
        r.st.due_mask  = mask[DUE_MASK_W-1:0];
        r.st.ovf_task  = ovf[OVF_TASK_W-1:0];
        dir_table.push_back(r);
    endfunction

    function automatic t_item random_item();
        t_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)      it.kind = KIND_SCHEDULE;
        else if (r < 35) it.kind = KIND_SET;
        else if (r < 65) it.kind = KIND_TICK;
        else             it.kind = KIND_QUERY;
        it.task_id = TASK_REQ_W'($urandom_range(0, TASKS - 1));
        // Keep periods mostly short so tasks come due often
        r = $urandom_range(0, 9);
        if (r == 0)      it.period = '0;
        else if (r == 1) it.period = PERIOD_W'($urandom);
        else             it.period = PERIOD_W'($urandom_range(1, 6));
        it.enable  = ($urandom_range(0, 3) != 0);
        it.overrun = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    // Offer one item in bursts with random gaps; predict it once accepted
    task automatic offer_item(t_item it, bit typed, t_status typed_st);
        int gap;
        t_status st;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_kind         <= it.kind;
        i_task_req     <= it.task_id;
        i_period       <= it.period;
        i_enable       <= it.enable;
        i_tick_overrun <= it.overrun;
        do @(posedge i_clk); while (o_stall);
        st = apply_item(it);
        pending_status.push_back(typed ? typed_st : st);
        kind_seen[it.kind]++;
        if (st.run_now) due_answers++;
        if (it.kind == KIND_QUERY && it.overrun) overrun_queries++;
        @(negedge i_clk);
    endtask

    // Receiver: stall on its own pattern, with one long hold-off on request
    initial begin : receiver
        int hold_left;
        int mode_left;
        int phase;
        t_stall_mode mode;
        hold_left = 0;
        mode_left = 0;
        phase     = 0;
        mode      = STALL_NONE;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 1) == 0);
                    default:     i_stall <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_status exp_st;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result %0d: run_now %0b due_mask %02h overflow_task %0d",
                             results_seen, o_run_now, o_due_mask, o_overflow_task);
            end else begin
                exp_st = pending_status.pop_front();
                if (o_run_now !== exp_st.run_now || o_due_mask !== exp_st.due_mask ||
                    o_overflow_task !== exp_st.ovf_task) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("result %0d wrong (exp/got): run_now %0b/%0b due_mask %02h/%02h %s %0d/%0d",
                                 results_seen, exp_st.run_now, o_run_now, exp_st.due_mask,
                                 o_due_mask, "overflow_task", exp_st.ovf_task, o_overflow_task);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Main sequence: reset, directed table, random items, drain
    initial begin : stimulus
        int t;
        t_status none;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_kind         = KIND_SCHEDULE;
        i_task_req     = '0;
        i_period       = '0;
        i_enable       = 1'b0;
        i_tick_overrun = 1'b0;
        hold_request   = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        due_answers    = 0;
        overrun_queries = 0;
        burst_left     = 0;
        none           = '{1'b0, '0, '0};
        for (t = 0; t < 4; t++) kind_seen[t] = 0;
        for (t = 0; t < TASKS; t++) begin
            tbl_active[t] = 1'b0;
            tbl_due[t]    = 1'b0;
            tbl_count[t]  = '0;
            tbl_reload[t] = '0;
        end
        tbl_ovf = '0;

        // Idle table after reset, then wrap, reload, pause and overrun cases
        add_row(KIND_TICK,     0, 0,       0, 0, 1, 0, 8'h00, 0);
        add_row(KIND_QUERY,    0, 0,       0, 0, 1, 0, 8'h00, 0);
        add_row(KIND_QUERY,    7, 0,       0, 1, 1, 0, 8'h00, 7);
        add_row(KIND_SCHEDULE, 0, 1,       0, 0, 0, 0, 0, 0);
        add_row(KIND_SCHEDULE, 7, 'hFFFF,  0, 0, 0, 0, 0, 0);
        add_row(KIND_SCHEDULE, 3, 0,       0, 0, 0, 0, 0, 0);
        add_row(KIND_SCHEDULE, 5, 2,       0, 0, 0, 0, 0, 0);
        add_row(KIND_TICK,     0, 0,       0, 0, 0, 0, 0, 0);
        add_row(KIND_QUERY,    0, 0,       0, 0, 0, 0, 0, 0);
        add_row(KIND_QUERY,    0, 0,       0, 1, 0, 0, 0, 0);
        add_row(KIND_TICK,     0, 0,       0, 0, 0, 0, 0, 0);
        add_row(KIND_SET,      0, 0,       0, 0, 0, 0, 0, 0);
        add_row(KIND_TICK,     0, 0,       0, 0, 0, 0, 0, 0);
        add_row(KIND_SET,      0, 0,       1, 0, 0, 0, 0, 0);
        add_row(KIND_SET,      6, 0,       1, 0, 0, 0, 0, 0);
        add_row(KIND_TICK,     0, 0,       0, 0, 0, 0, 0, 0);
        add_row(KIND_QUERY,    5, 0,       0, 0, 0, 0, 0, 0);
        add_row(KIND_SCHEDULE, 2, 'h8000,  1, 1, 0, 0, 0, 0);
        add_row(KIND_QUERY,    3, 'hFFFF,  1, 1, 0, 0, 0, 0);
        add_row(KIND_SET,      7, 'h5555,  0, 1, 0, 0, 0, 0);
        add_row(KIND_TICK,     7, 'hAAAA,  1, 1, 0, 0, 0, 0);
        add_row(KIND_QUERY,    7, 0,       0, 0, 0, 0, 0, 0);
        add_row(KIND_SCHEDULE, 4, 'h5555,  0, 0, 0, 0, 0, 0);
        add_row(KIND_SCHEDULE, 1, 'hAAAA,  1, 0, 0, 0, 0, 0);
        add_row(KIND_TICK,     0, 0,       0, 0, 0, 0, 0, 0);

        // Hold reset, then release it
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[r]) offer_item(dir_table[r].it, dir_table[r].typed, dir_table[r].st);

        for (t = 0; t < RAND_ITEMS; t++) begin
            // Hold off the receiver once so the block backs up into its input
            if (t == HOLD_AT) hold_request = 1'b1;
            offer_item(random_item(), 1'b0, none);
        end
        i_valid <= 1'b0;

        // Drain, then keep the clock running to catch stray results
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (2 * TASKS + 8) @(posedge i_clk);

        $display("covered %0d results: %0d schedule, %0d set, %0d tick, %0d query items",
                 results_seen, kind_seen[KIND_SCHEDULE], kind_seen[KIND_SET],
                 kind_seen[KIND_TICK], kind_seen[KIND_QUERY]);
        $display("queries answered due: %0d, overrun queries: %0d, mismatches: %0d",
                 due_answers, overrun_queries, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
